// ===== hw/rtl/prs_pkg.sv =====
// Shared types, codes and constants of the PLL frequency ramp sequencer.
// No dependencies; used by prs_step and pll_frequency_ramp_sequencer.

package prs_pkg;

    // sequencer phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CHECK = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_WRITE = 2'd3;

    // action codes carried on s_tuser
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RAISE = 2'd1;
    localparam logic [1:0] ACT_LOWER = 2'd2;

    // write targets carried on m_tuser
    localparam logic TGT_RATIO = 1'b0;
    localparam logic TGT_MUL   = 1'b1;

    // register encodings
    localparam logic [7:0]  RATIO_IDX   = 8'd5;
    localparam logic [7:0]  APPLY_BIT   = 8'h80;
    localparam logic [31:0] RATIO_WORD  = {24'd0, APPLY_BIT | RATIO_IDX};
    localparam logic [15:0] MSB_LOWER   = 16'h0124;
    localparam int          FLAG_BIT    = 27 - 16;
    localparam logic [15:0] MSB_RAISE   = MSB_LOWER | (16'd1 << FLAG_BIT);
    localparam logic [7:0]  DEN         = 8'd20;

    // frequencies in MHz
    localparam logic [8:0] DEFAULT_MHZ    = 9'd333;
    localparam logic [8:0] STEP_MHZ       = 9'd18;
    localparam logic [8:0] FIRST_NEXT_MHZ = DEFAULT_MHZ + 9'd37;
    localparam logic [8:0] TARGET_RESET   = 9'd444;

    // floor(mhz*20/37) capped at 255, as mhz * 566800 >> 20 (just above 20*2^20/37), exact for mhz below 13107
    localparam logic [30:0] NUMER_MUL = 31'd566800;

    function automatic logic [7:0] numer_of(input logic [10:0] mhz);
        logic [30:0] prod;
        logic [10:0] quot;
        prod = {20'd0, mhz} * NUMER_MUL;
        quot = prod[30:20];
        numer_of = (quot > 11'd255) ? 8'hFF : quot[7:0];
    endfunction

    localparam logic [7:0] NUMER_DEFAULT    = numer_of({2'b00, DEFAULT_MHZ});
    localparam logic [7:0] NUMER_FIRST_NEXT = numer_of({2'b00, FIRST_NEXT_MHZ});

    // sequencer state
    typedef struct packed {
        logic [1:0] phase;
        logic       going_down;
        logic [7:0] ramp_value;
        logic [7:0] ramp_end;
        logic [8:0] pass_base;
    } state_t;

    // one input item
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] ratio_readback;
        logic       mul_flag_readback;
    } item_t;

    // one result item
    typedef struct packed {
        logic        write_valid;
        logic        write_target;
        logic [31:0] write_data;
        logic        busy;
        logic        done;
    } result_t;

endpackage

// ===== hw/rtl/pll_frequency_ramp_sequencer.sv =====
// PLL frequency ramp sequencer: input register, state and result register.
// Depends on prs_pkg and prs_step.
//
// Usage: each item on the s_ channel is one tick of the sequencer. s_tuser
// carries the action (tick, raise to target, lower to default) and s_tdata
// the readbacks of the ratio-select register and the multiplier flag. For
// each item one result comes out on the m_ channel: an optional register
// write (m_tuser says whether and where, m_tdata the word) plus busy and
// done status. The ramp target is written through cfg_we / cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Timing: an accepted item fills the input register and moves on to the result
// register when that is free; m_ shows it from the result register.
// Throughput: one item per cycle while results are taken; the state update for
// an item is done in one pass of prs_step between the input and result register.
// Reset: the sequencer goes idle, both registers empty, target back to 444.
// Stall: when m_tready is low the result register holds, the input register
// then fills and s_tready drops until the result is taken.

module pll_frequency_ramp_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // action
    input  logic [15:0] s_tdata,    // ratio_readback [7:0], mul_flag_readback [8], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,    // write_valid [0], write_target [1]
    output logic [39:0] m_tdata     // write_data [31:0], busy_res [32], done_res [33], zeros
);

    logic [8:0]       target_mhz_reg;
    logic             in_valid_reg;
    prs_pkg::item_t   in_item_reg;
    prs_pkg::state_t  state_reg;
    prs_pkg::state_t  state_next;
    prs_pkg::result_t step_res;
    logic             out_valid_reg;
    prs_pkg::result_t out_res_reg;
    logic             out_free;
    logic             advance;

    // handshake control
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // target register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_mhz_reg <= prs_pkg::TARGET_RESET;
        end else if (cfg_we) begin
            target_mhz_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.action            <= s_tuser;
            in_item_reg.ratio_readback    <= s_tdata[7:0];
            in_item_reg.mul_flag_readback <= s_tdata[8];
        end
    end

    // step logic
    prs_step u_step (
        .st         (state_reg),
        .item       (in_item_reg),
        .target_mhz (target_mhz_reg),
        .st_next    (state_next),
        .res        (step_res)
    );

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= prs_pkg::PH_IDLE;
            state_reg.going_down <= 1'b0;
            state_reg.ramp_value <= 8'd0;
            state_reg.ramp_end   <= 8'd0;
            state_reg.pass_base  <= prs_pkg::DEFAULT_MHZ;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.write_target, out_res_reg.write_valid};
    assign m_tdata  = {6'd0, out_res_reg.done, out_res_reg.busy, out_res_reg.write_data};

endmodule

// ===== hw/rtl/prs_step.sv =====
// Next-state and result logic of the ramp sequencer for one item.
// Depends on prs_pkg (state, item and result types, codes, numer_of).

module prs_step (
    input  prs_pkg::state_t  st,
    input  prs_pkg::item_t   item,
    input  logic [8:0]       target_mhz,
    output prs_pkg::state_t  st_next,
    output prs_pkg::result_t res
);

    logic        raise_start;
    logic [8:0]  pass_base_cur;
    logic [9:0]  nb_mhz;
    logic [10:0] nn_mhz;
    logic [7:0]  numer_target;
    logic [7:0]  numer_nb;
    logic [7:0]  numer_nn;

    // pass base after a raise request restarts the walk
    assign raise_start   = (st.phase == prs_pkg::PH_IDLE) && (item.action == prs_pkg::ACT_RAISE);
    assign pass_base_cur = raise_start ? prs_pkg::DEFAULT_MHZ : st.pass_base;

    // next pass frequencies and their numerators
    assign nb_mhz       = {1'b0, pass_base_cur} + {1'b0, prs_pkg::STEP_MHZ};
    assign nn_mhz       = {1'b0, nb_mhz} + {2'b00, prs_pkg::STEP_MHZ};
    assign numer_target = prs_pkg::numer_of({2'b00, target_mhz});
    assign numer_nb     = prs_pkg::numer_of({2'b00, nb_mhz[8:0]});
    assign numer_nn     = prs_pkg::numer_of({2'b00, nn_mhz[8:0]});

    always_comb begin
        prs_pkg::state_t nx;
        logic [1:0]      ph;
        logic            wv;
        logic            wt;
        logic [31:0]     wd;
        logic            done;

        nx   = st;
        ph   = st.phase;
        wv   = 1'b0;
        wt   = prs_pkg::TGT_RATIO;
        wd   = 32'd0;
        done = 1'b0;

        // request handling while idle
        if (ph == prs_pkg::PH_IDLE) begin
            if (item.action == prs_pkg::ACT_RAISE) begin
                nx.going_down = 1'b0;
                nx.pass_base  = prs_pkg::DEFAULT_MHZ;
                if (prs_pkg::FIRST_NEXT_MHZ <= target_mhz) begin
                    nx.ramp_value = prs_pkg::NUMER_DEFAULT;
                    nx.ramp_end   = prs_pkg::NUMER_FIRST_NEXT;
                    ph            = prs_pkg::PH_CHECK;
                end else begin
                    done = 1'b1;
                end
            end else if (item.action == prs_pkg::ACT_LOWER) begin
                if (item.mul_flag_readback) begin
                    nx.going_down = 1'b1;
                    nx.ramp_value = numer_target;
                    nx.ramp_end   = prs_pkg::NUMER_DEFAULT;
                    ph            = prs_pkg::PH_CHECK;
                end else begin
                    done = 1'b1;
                end
            end
        end

        // ratio-select check and wait
        if (ph == prs_pkg::PH_CHECK) begin
            if (item.ratio_readback != prs_pkg::RATIO_IDX) begin
                wv = 1'b1;
                wt = prs_pkg::TGT_RATIO;
                wd = prs_pkg::RATIO_WORD;
                ph = prs_pkg::PH_WAIT;
            end else begin
                ph = prs_pkg::PH_WRITE;
            end
        end else if (ph == prs_pkg::PH_WAIT) begin
            if (item.ratio_readback == prs_pkg::RATIO_IDX) begin
                ph = prs_pkg::PH_WRITE;
            end
        end

        // at most one multiplier write per item
        if (ph == prs_pkg::PH_WRITE && !wv) begin
            if (nx.going_down) begin
                if (nx.ramp_value < nx.ramp_end) begin
                    ph   = prs_pkg::PH_IDLE;
                    done = 1'b1;
                end else begin
                    wv = 1'b1;
                    wt = prs_pkg::TGT_MUL;
                    wd = {prs_pkg::MSB_LOWER, nx.ramp_value, prs_pkg::DEN};
                    if (nx.ramp_value == nx.ramp_end) begin
                        ph   = prs_pkg::PH_IDLE;
                        done = 1'b1;
                    end else begin
                        nx.ramp_value = nx.ramp_value - 8'd1;
                    end
                end
            end else begin
                wv = 1'b1;
                wt = prs_pkg::TGT_MUL;
                wd = {prs_pkg::MSB_RAISE, nx.ramp_value, prs_pkg::DEN};
                if (nx.ramp_value >= nx.ramp_end) begin
                    nx.pass_base = nb_mhz[8:0];
                    if (nn_mhz <= {2'b00, target_mhz}) begin
                        nx.ramp_value = numer_nb;
                        nx.ramp_end   = numer_nn;
                        ph            = prs_pkg::PH_CHECK;
                    end else begin
                        ph   = prs_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                end else begin
                    nx.ramp_value = nx.ramp_value + 8'd1;
                end
            end
        end

        nx.phase         = ph;
        st_next          = nx;
        res.write_valid  = wv;
        res.write_target = wt;
        res.write_data   = wd;
        res.busy         = (ph != prs_pkg::PH_IDLE);
        res.done         = done;
    end

endmodule
